// File: design/midpoint_ray_triangulation_macros.svh
// ----------------------------------------------------------------------------
// midpoint ray triangulation assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_RAY_TRIANGULATION_MACROS_SVH
`define MIDPOINT_RAY_TRIANGULATION_MACROS_SVH

// same-cycle implication
`define MRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/mrt_pkg.sv
// ----------------------------------------------------------------------------
// mrt_pkg
// widths and constants of the midpoint ray triangulation pipeline
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam int W_IN   = 32;   // q16.16 field
  localparam int W_DOT  = 67;   // dot product, scale 2^32
  localparam int W_DET  = 135;  // determinant and numerators, scale 2^64
  localparam int W_NUM  = 169;  // coordinate numerator
  localparam int W_SUM  = 170;  // numerator plus determinant
  localparam int W_DEN  = 136;  // twice the determinant
  localparam int Q_BITS = 33;   // quotient bits resolved by the divider
  localparam int THR_SHIFT = 48;

  localparam logic [W_IN-1:0] POINT_NONE = 32'hFFFF0000;
  localparam logic [W_IN-1:0] SAT_MAX    = 32'h7FFFFFFF;
  localparam logic [W_IN-1:0] SAT_MIN    = 32'h80000000;

  typedef logic signed [W_IN-1:0] q16_t;

endpackage

// File: design/mrt_mul.sv
// ----------------------------------------------------------------------------
// mrt_mul
// pipelined signed multiplier, one pair of 32-bit digits per stage
// ----------------------------------------------------------------------------
module mrt_mul
  import mrt_pkg::*;
#(
  parameter int WA = 67,
  parameter int WB = 67
) (
  input  logic                 clk,
  input  logic signed [WA-1:0] a,
  input  logic signed [WB-1:0] b,
  output logic signed [WA+WB-1:0] p
);

  localparam int D   = 32;
  localparam int NA  = (WA + D - 1) / D;
  localparam int NB  = (WB + D - 1) / D;
  localparam int NS  = NA * NB;
  localparam int WAX = NA * D;
  localparam int WBX = NB * D;
  localparam int WPX = WAX + WBX;

  logic signed [WAX-1:0] ax;
  logic signed [WBX-1:0] bx;
  logic signed [WAX-1:0] a_r   [NS];
  logic signed [WBX-1:0] b_r   [NS];
  logic signed [WPX-1:0] acc_r [NS];

  assign ax = WAX'(a);
  assign bx = WBX'(b);

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int I = k / NB;
    localparam int J = k % NB;
    logic signed [WAX-1:0] a_in;
    logic signed [WBX-1:0] b_in;
    logic signed [WPX-1:0] acc_in;
    logic signed [D:0]     da;
    logic signed [D:0]     db;
    logic signed [2*D+1:0] part;

    if (k == 0) begin : g_first
      assign a_in   = ax;
      assign b_in   = bx;
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[k-1];
      assign b_in   = b_r[k-1];
      assign acc_in = acc_r[k-1];
    end

    // top digits carry the sign, lower digits are unsigned
    if (I == NA - 1) begin : g_atop
      assign da = {a_in[D*I+D-1], a_in[D*I +: D]};
    end else begin : g_alow
      assign da = {1'b0, a_in[D*I +: D]};
    end

    if (J == NB - 1) begin : g_btop
      assign db = {b_in[D*J+D-1], b_in[D*J +: D]};
    end else begin : g_blow
      assign db = {1'b0, b_in[D*J +: D]};
    end

    assign part = da * db;

    always_ff @(posedge clk) begin
      a_r[k]   <= a_in;
      b_r[k]   <= b_in;
      acc_r[k] <= acc_in + (WPX'(part) <<< (D * (I + J)));
    end
  end

  assign p = acc_r[NS-1][WA+WB-1:0];

endmodule

// File: design/mrt_div.sv
// ----------------------------------------------------------------------------
// mrt_div
// pipelined restoring divider with rounding fix-up and 32-bit saturation
// ----------------------------------------------------------------------------
module mrt_div
  import mrt_pkg::*;
#(
  parameter int WM = 170,
  parameter int WD = 136
) (
  input  logic          clk,
  input  logic [WM-1:0] mag,
  input  logic [WD-1:0] den,
  input  logic          neg,
  output logic [W_IN-1:0] res
);

  localparam int WC = WM + Q_BITS;

  logic [WM-1:0]     rem_r [Q_BITS+1];
  logic [Q_BITS-1:0] quo_r [Q_BITS+1];
  logic [WD-1:0]     den_r [Q_BITS+1];
  logic              neg_r [Q_BITS+1];
  logic              sat_r [Q_BITS+1];
  logic [W_IN-1:0]   res_r;
  logic [W_IN-1:0]   res_nxt;
  logic [Q_BITS:0]   ceil_q;

  // quotient of 2^33 or more saturates whatever the sign
  always_ff @(posedge clk) begin
    rem_r[0] <= mag;
    quo_r[0] <= '0;
    den_r[0] <= den;
    neg_r[0] <= neg;
    sat_r[0] <= WC'(mag) >= (WC'(den) << Q_BITS);
  end

  for (genvar j = 0; j < Q_BITS; j++) begin : g_step
    localparam int SH = Q_BITS - 1 - j;
    logic [WC-1:0] trial;
    logic          take;

    assign trial = WC'(den_r[j]) << SH;
    assign take  = WC'(rem_r[j]) >= trial;

    always_ff @(posedge clk) begin
      rem_r[j+1] <= take ? WM'(WC'(rem_r[j]) - trial) : rem_r[j];
      quo_r[j+1] <= quo_r[j] | (Q_BITS'(take) << SH);
      den_r[j+1] <= den_r[j];
      neg_r[j+1] <= neg_r[j];
      sat_r[j+1] <= sat_r[j];
    end
  end

  assign ceil_q = (Q_BITS+1)'(quo_r[Q_BITS]) + (Q_BITS+1)'(|rem_r[Q_BITS]);

  always_comb begin
    if (sat_r[Q_BITS]) begin
      res_nxt = neg_r[Q_BITS] ? SAT_MIN : SAT_MAX;
    end else if (!neg_r[Q_BITS]) begin
      res_nxt = (quo_r[Q_BITS] > Q_BITS'(SAT_MAX)) ? SAT_MAX : quo_r[Q_BITS][W_IN-1:0];
    end else begin
      // negative side rounds the magnitude up, then negates
      res_nxt = (ceil_q > (Q_BITS+1)'(SAT_MIN)) ? SAT_MIN : W_IN'(~ceil_q + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

// File: design/midpoint_ray_triangulation.sv
// ----------------------------------------------------------------------------
// midpoint_ray_triangulation
// midpoint of the shortest segment between two rays, exact q16.16 pipeline
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  input   | start / busy         | in_dir1_*, in_dir2_*, in_base_*
//  result  | out_valid strobe     | out_point_*, out_found
//  config  | cfg_valid / cfg_ready| cfg_parallel_threshold
//
//  one item enters per cycle, busy never rises; the latency is set by
//  the 33-step pipelined divider, the 9-stage dot product multipliers and the
//  5-stage coordinate multipliers
//  rst_n clears the valid chain and loads the threshold with 7
//  results cannot be stalled; each leaves on a single-cycle out_valid strobe
// ----------------------------------------------------------------------------
module midpoint_ray_triangulation
  import mrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  q16_t        in_dir1_x,
  input  q16_t        in_dir1_y,
  input  q16_t        in_dir1_z,
  input  q16_t        in_dir2_x,
  input  q16_t        in_dir2_y,
  input  q16_t        in_dir2_z,
  input  q16_t        in_base_x,
  input  q16_t        in_base_y,
  input  q16_t        in_base_z,
  output logic        out_valid,
  output q16_t        out_point_x,
  output q16_t        out_point_y,
  output q16_t        out_point_z,
  output logic        out_found,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_parallel_threshold
);

`include "midpoint_ray_triangulation_macros.svh"

  localparam int LAT  = 58;
  localparam int VDLY = 14;  // vectors, stage 1 to stage 14
  localparam int FDLY = 44;  // found flag, stage 14 to stage 57
  localparam int DDLY = 8;   // determinant, stage 14 to stage 21

  logic [30:0] thr_r;
  logic        vld_r [LAT];

  q16_t v1_r [VDLY][3];
  q16_t v2_r [VDLY][3];
  q16_t t_r  [VDLY][3];

  logic signed [2*W_IN-1:0] prod_r [5][3];
  logic signed [W_DOT-1:0]  dot_r  [5];
  logic signed [2*W_DOT-1:0] mp [6];

  logic signed [W_DET-1:0] dd_r, n1d_r, n2d_r;
  logic signed [W_DET-1:0] d_r [DDLY];
  logic signed [W_DET-1:0] n1_r, n2_r;
  logic        fnd_r [FDLY];
  logic [W_DET:0] dabs;

  logic signed [W_DET+W_IN-1:0] td [3], vn1 [3], vn2 [3];
  logic signed [W_NUM-1:0] num_r [3];
  logic signed [W_SUM-1:0] sum_r [3];
  logic [W_SUM-1:0] mag_r [3];
  logic             neg_r [3];
  logic [W_DEN-1:0] den_r;
  logic [W_IN-1:0]  res [3];

  q16_t pt_x_r, pt_y_r, pt_z_r;
  logic found_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 31'd7;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_parallel_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= start && !busy;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // stage 1: capture, then carry the vectors down to the per-coordinate products
  always_ff @(posedge clk) begin
    v1_r[0][0] <= in_dir1_x; v1_r[0][1] <= in_dir1_y; v1_r[0][2] <= in_dir1_z;
    v2_r[0][0] <= in_dir2_x; v2_r[0][1] <= in_dir2_y; v2_r[0][2] <= in_dir2_z;
    t_r[0][0]  <= in_base_x; t_r[0][1]  <= in_base_y; t_r[0][2]  <= in_base_z;
    for (int k = 1; k < VDLY; k++) begin
      v1_r[k] <= v1_r[k-1];
      v2_r[k] <= v2_r[k-1];
      t_r[k]  <= t_r[k-1];
    end
  end

  // stage 2: products for v1v2, v1v1, v2v2, tv1, tv2
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_r[0][i] <= v1_r[0][i] * v2_r[0][i];
      prod_r[1][i] <= v1_r[0][i] * v1_r[0][i];
      prod_r[2][i] <= v2_r[0][i] * v2_r[0][i];
      prod_r[3][i] <= t_r[0][i] * v1_r[0][i];
      prod_r[4][i] <= t_r[0][i] * v2_r[0][i];
    end
  end

  // stage 3: dot products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 5; k++) begin
      dot_r[k] <= W_DOT'(prod_r[k][0]) + W_DOT'(prod_r[k][1]) + W_DOT'(prod_r[k][2]);
    end
  end

  // stages 4..12: the six wide products
  mrt_mul #(.WA(W_DOT), .WB(W_DOT)) u_m0 (.clk(clk), .a(dot_r[0]), .b(dot_r[0]), .p(mp[0]));
  mrt_mul #(.WA(W_DOT), .WB(W_DOT)) u_m1 (.clk(clk), .a(dot_r[1]), .b(dot_r[2]), .p(mp[1]));
  mrt_mul #(.WA(W_DOT), .WB(W_DOT)) u_m2 (.clk(clk), .a(dot_r[4]), .b(dot_r[0]), .p(mp[2]));
  mrt_mul #(.WA(W_DOT), .WB(W_DOT)) u_m3 (.clk(clk), .a(dot_r[3]), .b(dot_r[2]), .p(mp[3]));
  mrt_mul #(.WA(W_DOT), .WB(W_DOT)) u_m4 (.clk(clk), .a(dot_r[4]), .b(dot_r[1]), .p(mp[4]));
  mrt_mul #(.WA(W_DOT), .WB(W_DOT)) u_m5 (.clk(clk), .a(dot_r[3]), .b(dot_r[0]), .p(mp[5]));

  // stage 13: determinant and numerators
  always_ff @(posedge clk) begin
    dd_r  <= W_DET'(mp[0]) - W_DET'(mp[1]);
    n1d_r <= W_DET'(mp[2]) - W_DET'(mp[3]);
    n2d_r <= W_DET'(mp[4]) - W_DET'(mp[5]);
  end

  // stage 14: make the determinant positive, test for parallel rays
  assign dabs = dd_r[W_DET-1] ? (W_DET+1)'(-dd_r) : (W_DET+1)'(dd_r);

  always_ff @(posedge clk) begin
    d_r[0]   <= dd_r[W_DET-1] ? -dd_r  : dd_r;
    n1_r     <= dd_r[W_DET-1] ? -n1d_r : n1d_r;
    n2_r     <= dd_r[W_DET-1] ? -n2d_r : n2d_r;
    fnd_r[0] <= (dabs != '0) &&
                (dabs >= ((W_DET+1)'(thr_r) << THR_SHIFT));
    for (int k = 1; k < DDLY; k++) d_r[k] <= d_r[k-1];
    for (int k = 1; k < FDLY; k++) fnd_r[k] <= fnd_r[k-1];
  end

  // stages 15..19: per-coordinate products
  for (genvar c = 0; c < 3; c++) begin : g_coord
    mrt_mul #(.WA(W_IN), .WB(W_DET)) u_td
      (.clk(clk), .a(t_r[VDLY-1][c]),  .b(d_r[0]), .p(td[c]));
    mrt_mul #(.WA(W_IN), .WB(W_DET)) u_v1
      (.clk(clk), .a(v1_r[VDLY-1][c]), .b(n1_r),   .p(vn1[c]));
    mrt_mul #(.WA(W_IN), .WB(W_DET)) u_v2
      (.clk(clk), .a(v2_r[VDLY-1][c]), .b(n2_r),   .p(vn2[c]));

    // stage 20 sum, stage 21 add half divisor, stage 22 sign and magnitude
    always_ff @(posedge clk) begin
      num_r[c] <= W_NUM'(td[c]) + W_NUM'(vn1[c]) + W_NUM'(vn2[c]);
      sum_r[c] <= W_SUM'(num_r[c]) + W_SUM'(d_r[DDLY-2]);
      neg_r[c] <= sum_r[c][W_SUM-1];
      mag_r[c] <= sum_r[c][W_SUM-1] ? W_SUM'(-sum_r[c]) : W_SUM'(sum_r[c]);
    end

    mrt_div #(.WM(W_SUM), .WD(W_DEN)) u_div
      (.clk(clk), .mag(mag_r[c]), .den(den_r), .neg(neg_r[c]), .res(res[c]));
  end

  always_ff @(posedge clk) begin
    den_r <= {d_r[DDLY-1], 1'b0};
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= vld_r[LAT-2] && fnd_r[FDLY-1];
    end
    pt_x_r <= fnd_r[FDLY-1] ? res[0] : POINT_NONE;
    pt_y_r <= fnd_r[FDLY-1] ? res[1] : POINT_NONE;
    pt_z_r <= fnd_r[FDLY-1] ? res[2] : POINT_NONE;
  end

  assign out_valid   = vld_r[LAT-1];
  assign out_found   = found_r;
  assign out_point_x = pt_x_r;
  assign out_point_y = pt_y_r;
  assign out_point_z = pt_z_r;

  `MRT_ASSERT_IMP(a_found_valid, out_found, out_valid)
  `MRT_ASSERT_IMP(a_none_point, out_valid && !out_found,
                  out_point_x == POINT_NONE && out_point_z == POINT_NONE)
  `MRT_ASSERT_NXT(a_found_tracks, vld_r[LAT-2] && fnd_r[FDLY-1], out_found && out_valid)

endmodule
